### rtl/core/gcbp_pkg.sv
// ----------------------------------------------------------------------------
// gcbp_pkg
// Shared types, constants and helpers of the glyph column byte packer.
// ----------------------------------------------------------------------------
package gcbp_pkg;

  localparam int BYTE_W          = 8;
  localparam int ROW_BUF_BYTES   = 32;
  localparam int ROW_BUF_IDX_W   = $clog2(ROW_BUF_BYTES);
  localparam int JOB_QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int PHASE_W         = 3;
  localparam int JOB_BYTES       = 4;

  localparam logic [BYTE_W-1:0] PAIR_MASK = 8'h03;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VERTICAL_MODE = 2'd0,
    REG_DOUBLE_SIZE   = 2'd1,
    REG_COLUMN_PHASE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_FINISH = 2'd1
  } command_t;

  typedef enum logic [1:0] {
    JOB_VERT   = 2'd0,
    JOB_HORZ   = 2'd1,
    JOB_FINISH = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic               vertical_mode;
    logic               double_size;
    logic [PHASE_W-1:0] column_phase;
  } cfg_t;

  typedef struct packed {
    job_kind_t                          kind;
    logic [JOB_BYTES-1:0][BYTE_W-1:0]   bytes;
  } job_t;

  function automatic logic [BYTE_W-1:0] widen_nibble(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      if (nib[k]) begin
        r = r | (PAIR_MASK << (2 * k));
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/gcbp_in_if.sv
// ----------------------------------------------------------------------------
// gcbp_in_if
// Input channel carrying one glyph column or a finish command.
// ----------------------------------------------------------------------------
interface gcbp_in_if;
  import gcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] first_font_byte;
  logic [BYTE_W-1:0] second_font_byte;

  modport source (output valid, output command, output first_font_byte,
                  output second_font_byte, input ready);
  modport sink   (input valid, input command, input first_font_byte,
                  input second_font_byte, output ready);
endinterface

### rtl/core/gcbp_out_if.sv
// ----------------------------------------------------------------------------
// gcbp_out_if
// Result channel carrying one panel byte per transaction.
// ----------------------------------------------------------------------------
interface gcbp_out_if;
  import gcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] panel_byte;
  logic              last;

  modport source (output valid, output panel_byte, output last, input ready);
  modport sink   (input valid, input panel_byte, input last, output ready);
endinterface

### rtl/core/gcbp_cfg_if.sv
// ----------------------------------------------------------------------------
// gcbp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gcbp_cfg_if;
  import gcbp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/gcbp_front.sv
// ----------------------------------------------------------------------------
// gcbp_front
// Holds the configuration registers and turns each input transaction into a
// job for the back end, widening nibbles for doubled vertical columns.
// ----------------------------------------------------------------------------
module gcbp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [gcbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [gcbp_pkg::BYTE_W-1:0] in_first,
  input  logic [gcbp_pkg::BYTE_W-1:0] in_second,
  output logic                        job_valid,
  input  logic                        job_ready,
  output gcbp_pkg::job_t              job,
  output gcbp_pkg::cfg_t              cfg
);
  import gcbp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERTICAL_MODE: cfg_nxt.vertical_mode = cfg_data[0];
        REG_DOUBLE_SIZE:   cfg_nxt.double_size   = cfg_data[0];
        REG_COLUMN_PHASE:  cfg_nxt.column_phase  = cfg_data[PHASE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertical_mode <= 1'b1;
      cfg_r.double_size   <= 1'b0;
      cfg_r.column_phase  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    job.bytes    = '0;
    job.bytes[0] = in_first;
    job.bytes[1] = in_second;
    if ({1'b0, in_command} == CMD_FINISH) begin
      job.kind = JOB_FINISH;
    end else if (!cfg_r.vertical_mode) begin
      job.kind = JOB_HORZ;
    end else begin
      job.kind = JOB_VERT;
      if (cfg_r.double_size) begin
        job.bytes[0] = widen_nibble(in_first[7:4]);
        job.bytes[1] = widen_nibble(in_first[3:0]);
        job.bytes[2] = widen_nibble(in_second[7:4]);
        job.bytes[3] = widen_nibble(in_second[3:0]);
      end
    end
  end

  assign job_valid = in_valid;
  assign in_ready  = job_ready;
  assign cfg       = cfg_r;

endmodule

### rtl/core/gcbp_queue.sv
// ----------------------------------------------------------------------------
// gcbp_queue
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gcbp_queue #(
  parameter int DEPTH = gcbp_pkg::JOB_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gcbp_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gcbp_pkg::job_t pop_job
);
  import gcbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/core/gcbp_back.sv
// ----------------------------------------------------------------------------
// gcbp_back
// Carries out jobs: shifted vertical sending with carry bytes, transposition
// into the row buffer, and flushing of the row buffer one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gcbp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gcbp_pkg::cfg_t              cfg,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  gcbp_pkg::job_t              job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gcbp_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);
  import gcbp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_VSEND = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_t;

  back_state_t                      state_r, state_nxt;
  logic [JOB_BYTES-1:0][BYTE_W-1:0] src_r, src_nxt;
  logic [2:0]                       idx_r, idx_nxt;
  logic                             pend_r, pend_nxt;
  logic [BYTE_W-1:0]                carry_r, carry_nxt;
  logic [2:0]                       row_cnt_r, row_cnt_nxt;
  logic [PHASE_W-1:0]               pos_r, pos_nxt;
  logic [ROW_BUF_IDX_W-1:0]         fidx_r, fidx_nxt;
  logic [BYTE_W-1:0]                buf_r [ROW_BUF_BYTES];
  logic [BYTE_W-1:0]                buf_nxt [ROW_BUF_BYTES];
  logic                             out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]                out_byte_r, out_byte_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                     slot_free;
  logic [2:0]               vend;
  logic [2:0]               row_len;
  logic [2:0]               row_cnt_inc;
  logic [ROW_BUF_IDX_W-1:0] fend;
  logic [PHASE_W-1:0]       pair_pos;
  logic [BYTE_W-1:0]        hmask;
  logic [PHASE_W-1:0]       hpos_nxt;
  logic [PHASE_W-1:0]       start_pos;
  logic [BYTE_W-1:0]        src_byte;
  logic [2:0]               neg_off;
  logic                     adv;
  logic                     fin;

  assign slot_free   = !out_valid_r || out_ready;
  assign vend        = cfg.double_size ? 3'd7 : 3'd1;
  assign row_len     = cfg.double_size ? 3'd4 : 3'd2;
  assign row_cnt_inc = row_cnt_r + 1'b1;
  assign fend        = cfg.double_size ? ROW_BUF_IDX_W'(ROW_BUF_BYTES - 1)
                                       : ROW_BUF_IDX_W'(ROW_BUF_BYTES / 2 - 1);
  assign pair_pos    = {pos_r[2:1], 1'b0};
  assign hmask       = cfg.double_size ? (PAIR_MASK << (3'd6 - pair_pos))
                                       : (8'h80 >> pos_r);
  assign hpos_nxt    = cfg.double_size ? pair_pos + 3'd2 : pos_r + 3'd1;
  assign start_pos   = cfg.double_size ? {cfg.column_phase[2:1], 1'b0}
                                       : cfg.column_phase;
  assign src_byte    = src_r[idx_r[1:0]];
  assign neg_off     = 3'd0 - cfg.column_phase;
  assign job_ready   = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    carry_nxt     = carry_r;
    row_cnt_nxt   = row_cnt_r;
    pos_nxt       = pos_r;
    fidx_nxt      = fidx_r;
    buf_nxt       = buf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    adv           = 1'b0;
    fin           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          unique case (job.kind)
            JOB_VERT: begin
              src_nxt   = job.bytes;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_VSEND;
            end
            JOB_HORZ: begin
              for (int c = 0; c < 8; c++) begin
                if (job.bytes[1][7-c]) begin
                  if (cfg.double_size) begin
                    buf_nxt[2*c]   = buf_r[2*c] | hmask;
                    buf_nxt[2*c+1] = buf_r[2*c+1] | hmask;
                  end else begin
                    buf_nxt[c] = buf_r[c] | hmask;
                  end
                end
                if (job.bytes[0][7-c]) begin
                  if (cfg.double_size) begin
                    buf_nxt[16+2*c] = buf_r[16+2*c] | hmask;
                    buf_nxt[17+2*c] = buf_r[17+2*c] | hmask;
                  end else begin
                    buf_nxt[8+c] = buf_r[8+c] | hmask;
                  end
                end
              end
              pos_nxt = hpos_nxt;
              if (hpos_nxt == '0) begin
                fidx_nxt  = '0;
                state_nxt = ST_FLUSH;
              end
            end
            JOB_FINISH: begin
              carry_nxt   = '0;
              row_cnt_nxt = '0;
              pos_nxt     = start_pos;
              if (!cfg.vertical_mode && pos_r != '0) begin
                fidx_nxt  = '0;
                state_nxt = ST_FLUSH;
              end else begin
                for (int i = 0; i < ROW_BUF_BYTES; i++) begin
                  buf_nxt[i] = '0;
                end
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_VSEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pend_r) begin
            out_byte_nxt = carry_r;
            carry_nxt    = '0;
            row_cnt_nxt  = '0;
            pend_nxt     = 1'b0;
            adv          = 1'b1;
          end else if (cfg.column_phase == '0) begin
            out_byte_nxt = src_byte;
            adv          = 1'b1;
          end else begin
            out_byte_nxt = carry_r | (src_byte >> cfg.column_phase);
            carry_nxt    = src_byte << neg_off;
            row_cnt_nxt  = row_cnt_inc;
            if (row_cnt_inc >= row_len) begin
              pend_nxt = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          fin          = adv && (idx_r == vend);
          out_last_nxt = fin;
          if (fin) begin
            state_nxt = ST_IDLE;
          end else if (adv) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = buf_r[fidx_r];
          out_last_nxt  = (fidx_r == fend);
          if (fidx_r == fend) begin
            state_nxt = ST_IDLE;
            for (int i = 0; i < ROW_BUF_BYTES; i++) begin
              buf_nxt[i] = '0;
            end
          end else begin
            fidx_nxt = fidx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      carry_r     <= '0;
      row_cnt_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ROW_BUF_BYTES; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      carry_r     <= carry_nxt;
      row_cnt_r   <= row_cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      buf_r       <= buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    idx_r      <= idx_nxt;
    fidx_r     <= fidx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

### rtl/core/glyph_column_byte_packer.sv
// ----------------------------------------------------------------------------
// glyph_column_byte_packer
// Packs 16-pixel glyph columns into panel bytes, vertically with shifting or
// transposed through a row buffer.
//
//   Channel  Direction  Carries
//   in_ch    sink       command, first_font_byte, second_font_byte
//   out_ch   source     panel_byte, last
//   cfg_ch   sink       reg_index, wr_data (always ready)
//
// A vertical column produces 2 to 10 bytes at one byte per cycle from the
// output register when the output is not stalled; a horizontal column is ORed
// into the row buffer, and a completed or finished row buffer flushes 16 or 32
// bytes. Up to QUEUE_DEPTH jobs wait between the input and the executing back
// end, so input is still taken while the output stalls, until the queue is full.
// Reset clears the row buffer, carry and position and restores config defaults.
// ----------------------------------------------------------------------------
module glyph_column_byte_packer #(
  parameter int QUEUE_DEPTH = gcbp_pkg::JOB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  gcbp_in_if.sink           in_ch,
  gcbp_out_if.source        out_ch,
  gcbp_cfg_if.sink          cfg_ch
);
  import gcbp_pkg::*;

  cfg_t cfg;
  job_t front_job;
  job_t back_job;
  logic front_valid;
  logic front_ready;
  logic back_valid;
  logic back_ready;

  assign cfg_ch.ready = 1'b1;

  gcbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wr_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_command(in_ch.command),
    .in_first  (in_ch.first_font_byte),
    .in_second (in_ch.second_font_byte),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job),
    .cfg       (cfg)
  );

  gcbp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_job  (front_job),
    .pop_valid (back_valid),
    .pop_ready (back_ready),
    .pop_job   (back_job)
  );

  gcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .job_valid(back_valid),
    .job_ready(back_ready),
    .job      (back_job),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_byte (out_ch.panel_byte),
    .out_last (out_ch.last)
  );

endmodule

### rtl/core/gcbp_checker.sv
// ----------------------------------------------------------------------------
// gcbp_checker
// Port-level checks of the glyph column byte packer, bound to the top level.
// ----------------------------------------------------------------------------
module gcbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gcbp_pkg::BYTE_W-1:0] out_panel_byte,
  input logic                        out_last,
  input logic                        cfg_ready
);
  import gcbp_pkg::*;

  a_no_output_after_reset: assert property (
    @(posedge clk) !rst_n |=> !out_valid
  ) else $error("Output valid directly after reset.");

  a_ready_after_reset: assert property (
    @(posedge clk) !rst_n |=> in_ready
  ) else $error("Input not ready directly after reset.");

  a_stalled_output_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_panel_byte) && $stable(out_last)
  ) else $error("Stalled output transaction changed or was dropped.");

  a_cfg_always_ready: assert property (
    @(posedge clk) rst_n |-> cfg_ready
  ) else $error("Configuration channel not ready.");

endmodule

bind glyph_column_byte_packer gcbp_checker u_gcbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_panel_byte(out_ch.panel_byte),
  .out_last      (out_ch.last),
  .cfg_ready     (cfg_ch.ready)
);
